/* hw/rtl/bfie_pkg.sv */
// ----------------------------------------------------------------------------
// bfie_pkg
// Shared types and constants for the bit-addressed field pack/unpack store.
// ----------------------------------------------------------------------------
package bfie_pkg;

    localparam int STORE_BYTES = 4096;
    localparam int STORE_BITS  = STORE_BYTES * 8;

    // byte store is spread over eight banks so that five consecutive bytes
    // always sit in different banks
    localparam int NUM_BANKS   = 8;
    localparam int BANK_W      = 3;
    localparam int BANK_DEPTH  = STORE_BYTES / NUM_BANKS;
    localparam int ROW_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    localparam int POS_W       = 15;
    localparam int FW_W        = 6;
    localparam int VAL_W       = 32;
    localparam int MAX_FIELD   = 32;
    localparam int WIN_BYTES   = 5;
    localparam int WIN_W       = WIN_BYTES * 8;
    localparam int END_W       = $clog2(STORE_BITS + 64) + 1;

    localparam logic KIND_PACK   = 1'b0;
    localparam logic KIND_UNPACK = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS
    } state_t;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] bit_position;
        logic [FW_W-1:0]  field_width;
        logic [VAL_W-1:0] write_value;
    } in_word_t;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic             range_error;
    } out_word_t;

    typedef struct packed {
        logic [2:0]       bit_off;
        logic [FW_W-1:0]  field_width;
        logic [VAL_W-1:0] write_value;
    } field_ctl_t;

endpackage

/* hw/rtl/bfie_ram.sv */
// ----------------------------------------------------------------------------
// bfie_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfie_ram #(
    parameter int  DATA_W = 8,
    parameter int  DEPTH  = 512,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/bfie_field.sv */
// ----------------------------------------------------------------------------
// bfie_field
// Extracts a field from, and merges a field into, a five-byte window.
// ----------------------------------------------------------------------------
module bfie_field (
    input  bfie_pkg::field_ctl_t             ctl,
    input  logic [bfie_pkg::WIN_W-1:0]       win_in,
    output logic [bfie_pkg::WIN_W-1:0]       win_out,
    output logic [bfie_pkg::VAL_W-1:0]       field_out
);

    logic [bfie_pkg::WIN_W-1:0] shifted;
    logic [bfie_pkg::FW_W-1:0]  lsh;
    logic [bfie_pkg::VAL_W-1:0] ones_top;
    logic [bfie_pkg::VAL_W-1:0] val_top;
    logic [bfie_pkg::WIN_W-1:0] mask;
    logic [bfie_pkg::WIN_W-1:0] val_win;

    // field sits msb first at bit_off below the top of the window
    assign lsh       = bfie_pkg::FW_W'(bfie_pkg::MAX_FIELD) - ctl.field_width;
    assign shifted   = win_in << ctl.bit_off;
    assign field_out = shifted[bfie_pkg::WIN_W-1 -: bfie_pkg::VAL_W] >> lsh;

    assign ones_top  = {bfie_pkg::VAL_W{1'b1}} << lsh;
    assign val_top   = ctl.write_value << lsh;
    assign mask      = {ones_top, 8'h00} >> ctl.bit_off;
    assign val_win   = {val_top, 8'h00} >> ctl.bit_off;
    assign win_out   = (win_in & ~mask) | (val_win & mask);

endmodule

/* hw/rtl/bit_field_insert_extract_store.sv */
// ----------------------------------------------------------------------------
// bit_field_insert_extract_store
// Bit-addressed byte store: msb-first pack and unpack of 1 to 32 bit fields.
// ----------------------------------------------------------------------------
// output: m_valid is set as the access state ends, once the output has room
// input: a new word is taken only after the last one's read and, for a pack,
//   its write-back in the eight-bank byte memory (modify/write in ACCESS)
// reset: after aresetn a clearing pass zeroes the store, one row of eight
//   bytes a cycle, through all BANK_DEPTH rows; s_ready stays low
// ----------------------------------------------------------------------------
module bit_field_insert_extract_store (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bfie_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bfie_pkg::out_word_t m_data
);

    localparam int NB = bfie_pkg::NUM_BANKS;
    localparam int RW = bfie_pkg::ROW_W;
    localparam int BW = bfie_pkg::BANK_W;

    bfie_pkg::state_t    state_reg, state_next;
    logic [RW-1:0]       clr_row_reg, clr_row_next;
    logic                m_valid_reg, m_valid_next;
    bfie_pkg::out_word_t m_data_reg, m_data_next;

    // item held across the access state
    logic                kind_reg;
    logic                err_reg;
    logic [BW-1:0]       b0_reg;
    logic [2:0]          last_j_reg;
    bfie_pkg::field_ctl_t ctl_reg;
    logic [RW-1:0]       row_reg [NB];

    logic                accept;
    logic                out_free;
    logic                do_write;
    logic                in_err;
    logic [bfie_pkg::END_W-1:0] end_pos;
    logic [6:0]          span;
    logic [BW-1:0]       in_b0;
    logic [RW-1:0]       row_base;
    logic [RW-1:0]       in_row [NB];

    logic [7:0]          rdata [NB];
    logic [bfie_pkg::WIN_W-1:0] win;
    logic [bfie_pkg::WIN_W-1:0] win_new;
    logic [bfie_pkg::VAL_W-1:0] field_val;
    logic [7:0]          new_bytes [NB];

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // range check and bank mapping of the incoming word
    assign end_pos  = bfie_pkg::END_W'(s_data.bit_position)
                    + bfie_pkg::END_W'(s_data.field_width);
    assign in_err   = (s_data.field_width == '0)
                   || (s_data.field_width > bfie_pkg::FW_W'(bfie_pkg::MAX_FIELD))
                   || (end_pos > bfie_pkg::END_W'(bfie_pkg::STORE_BITS));
    assign span     = 7'(s_data.bit_position[2:0]) + 7'(s_data.field_width) - 7'd1;
    assign in_b0    = s_data.bit_position[5:3];
    assign row_base = RW'(s_data.bit_position >> 6);

    // window byte j comes from bank b0+j
    always_comb begin
        for (int j = 0; j < bfie_pkg::WIN_BYTES; j++) begin
            win[bfie_pkg::WIN_W-1-8*j -: 8] = rdata[BW'(b0_reg + BW'(j))];
        end
    end

    bfie_field u_field (
        .ctl       (ctl_reg),
        .win_in    (win),
        .win_out   (win_new),
        .field_out (field_val)
    );

    always_comb begin
        for (int j = 0; j < NB; j++) begin
            if (j < bfie_pkg::WIN_BYTES) begin
                new_bytes[j] = win_new[bfie_pkg::WIN_W-1-8*j -: 8];
            end else begin
                new_bytes[j] = 8'h00;
            end
        end
    end

    assign do_write = (state_reg == bfie_pkg::ST_ACCESS) && out_free && !err_reg
                   && (kind_reg == bfie_pkg::KIND_PACK);

    for (genvar k = 0; k < NB; k++) begin : g_bank
        logic [BW-1:0] jk;
        logic          we;
        logic [RW-1:0] waddr;
        logic [7:0]    wdata;

        // banks below the start bank hold the following row
        assign in_row[k] = row_base + RW'(BW'(k) < in_b0);
        assign jk        = BW'(k) - b0_reg;
        assign we        = (state_reg == bfie_pkg::ST_CLEAR) || (do_write && jk <= last_j_reg);
        assign waddr     = (state_reg == bfie_pkg::ST_CLEAR) ? clr_row_reg : row_reg[k];
        assign wdata     = (state_reg == bfie_pkg::ST_CLEAR) ? 8'h00 : new_bytes[jk];

        bfie_ram #(
            .DATA_W (8),
            .DEPTH  (bfie_pkg::BANK_DEPTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (we),
            .waddr (waddr),
            .wdata (wdata),
            .re    (accept),
            .raddr (in_row[k]),
            .rdata (rdata[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bfie_pkg::ST_CLEAR;
            clr_row_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_row_reg <= clr_row_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (accept) begin
            kind_reg            <= s_data.kind;
            err_reg             <= in_err;
            b0_reg              <= in_b0;
            last_j_reg          <= span[5:3];
            ctl_reg.bit_off     <= s_data.bit_position[2:0];
            ctl_reg.field_width <= s_data.field_width;
            ctl_reg.write_value <= s_data.write_value;
            row_reg             <= in_row;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_row_next = clr_row_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        s_ready      = 1'b0;
        unique case (state_reg)
            bfie_pkg::ST_CLEAR: begin
                clr_row_next = clr_row_reg + RW'(1);
                if (clr_row_reg == RW'(bfie_pkg::BANK_DEPTH - 1)) begin
                    state_next = bfie_pkg::ST_IDLE;
                end
            end
            bfie_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = bfie_pkg::ST_ACCESS;
                end
            end
            bfie_pkg::ST_ACCESS: begin
                // hold here until the output word has room
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next.range_error = err_reg;
                    m_data_next.read_value  =
                        (!err_reg && kind_reg == bfie_pkg::KIND_UNPACK) ? field_val : '0;
                    state_next = bfie_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bfie_pkg::ST_CLEAR;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
